/* design/e2q_pkg.sv */
// Shared types, widths and constants of the Euler angle to quaternion converter.
package e2q_pkg;

  localparam int NUM_LANES    = 3;
  localparam int LANE_ROLL    = 0;
  localparam int LANE_PITCH   = 1;
  localparam int LANE_YAW     = 2;

  localparam int ANGLE_W      = 16;
  localparam int QUAT_W       = 16;
  localparam int NUM_COMP     = 4;

  localparam int CORDIC_STEPS = 18;
  localparam int INT_FRAC     = 30;
  localparam int XW           = 33;
  localparam int ZW           = 26;
  localparam int CW           = 32;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [ZW-1:0] DEG_90      = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG_180     = 26'sd11796480;

  // Arctangent of 2^-i in degrees with 16 fraction bits.
  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666,   26'sd29335,   26'sd14668,  26'sd7334,   26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,    26'sd57,     26'sd29
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } lane_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } trig_t;

  typedef logic [NUM_COMP-1:0][QUAT_W-1:0] quat_t;

endpackage

/* design/e2q_cordic_cell.sv */
// One rotation-mode CORDIC iteration for all three angle lanes, with its pipeline register.
module e2q_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  e2q_pkg::lane_t [e2q_pkg::NUM_LANES-1:0] in_lanes_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output e2q_pkg::lane_t [e2q_pkg::NUM_LANES-1:0] out_lanes_o
);
  import e2q_pkg::*;

  logic                      valid_q;
  lane_t [NUM_LANES-1:0]     lanes_d, lanes_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lanes_d[l].flip = in_lanes_i[l].flip;
      if (!in_lanes_i[l].z[ZW-1]) begin
        lanes_d[l].x = in_lanes_i[l].x - (in_lanes_i[l].y >>> STEP);
        lanes_d[l].y = in_lanes_i[l].y + (in_lanes_i[l].x >>> STEP);
        lanes_d[l].z = in_lanes_i[l].z - ATAN_TAB[STEP];
      end else begin
        lanes_d[l].x = in_lanes_i[l].x + (in_lanes_i[l].y >>> STEP);
        lanes_d[l].y = in_lanes_i[l].y - (in_lanes_i[l].x >>> STEP);
        lanes_d[l].z = in_lanes_i[l].z + ATAN_TAB[STEP];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      lanes_q <= lanes_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_lanes_o = lanes_q;

endmodule

/* design/e2q_quat_tail.sv */
// Product pipeline that forms, rounds and saturates the four quaternion components.
module e2q_quat_tail #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  e2q_pkg::trig_t [e2q_pkg::NUM_LANES-1:0] in_trig_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output e2q_pkg::quat_t                        out_quat_o
);
  import e2q_pkg::*;

  localparam int NUM_STAGES = 5;
  localparam int PW         = 2 * CW;
  localparam int SH         = INT_FRAC - OUT_FRAC_BITS;
  localparam int OW         = CW + 3;

  localparam logic signed [PW-1:0] P_HALF = PW'(64'sd1 <<< (INT_FRAC - 1));
  localparam logic signed [OW-1:0] O_HALF = (SH > 0) ? (OW'(1) << ((SH > 0) ? SH - 1 : 0))
                                                     : '0;
  localparam logic signed [OW-1:0] SAT_HI = 35'sd32767;
  localparam logic signed [OW-1:0] SAT_LO = -35'sd32768;

  // Pair products: roll term times pitch term.
  localparam int PR_CC = 0;
  localparam int PR_SS = 1;
  localparam int PR_SC = 2;
  localparam int PR_CS = 3;
  // Triple products: pair k times yaw cosine at 2k and yaw sine at 2k+1.
  localparam int TR_CCC = 0;
  localparam int TR_CCS = 1;
  localparam int TR_SSC = 2;
  localparam int TR_SSS = 3;
  localparam int TR_SCC = 4;
  localparam int TR_SCS = 5;
  localparam int TR_CSC = 6;
  localparam int TR_CSS = 7;

  function automatic logic signed [CW-1:0] round_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + P_HALF;
    return t[INT_FRAC+CW-1:INT_FRAC];
  endfunction

  logic [NUM_STAGES-1:0]       valid_q;
  logic [NUM_STAGES-1:0]       rdy;

  logic signed [PW-1:0]        pp0_q [4];
  logic signed [CW-1:0]        cy0_q, sy0_q;
  logic signed [CW-1:0]        pr1_q [4];
  logic signed [CW-1:0]        cy1_q, sy1_q;
  logic signed [PW-1:0]        tp2_q [8];
  logic signed [CW-1:0]        tr3_q [8];
  logic signed [CW:0]          sum_d [NUM_COMP];
  logic signed [OW-1:0]        rnd_d [NUM_COMP];
  quat_t                       quat_d, quat_q;

  always_comb begin
    rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Output stage: sum or difference, round to the output format, saturate.
  always_comb begin
    sum_d[0] = {tr3_q[TR_CCC][CW-1], tr3_q[TR_CCC]} + {tr3_q[TR_SSS][CW-1], tr3_q[TR_SSS]};
    sum_d[1] = {tr3_q[TR_SCC][CW-1], tr3_q[TR_SCC]} - {tr3_q[TR_CSS][CW-1], tr3_q[TR_CSS]};
    sum_d[2] = {tr3_q[TR_CSC][CW-1], tr3_q[TR_CSC]} + {tr3_q[TR_SCS][CW-1], tr3_q[TR_SCS]};
    sum_d[3] = {tr3_q[TR_CCS][CW-1], tr3_q[TR_CCS]} - {tr3_q[TR_SSC][CW-1], tr3_q[TR_SSC]};
    for (int j = 0; j < NUM_COMP; j++) begin
      rnd_d[j] = (OW'(sum_d[j]) + O_HALF) >>> SH;
      if (rnd_d[j] > SAT_HI) begin
        quat_d[j] = SAT_HI[QUAT_W-1:0];
      end else if (rnd_d[j] < SAT_LO) begin
        quat_d[j] = SAT_LO[QUAT_W-1:0];
      end else begin
        quat_d[j] = rnd_d[j][QUAT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pp0_q[PR_CC] <= PW'(in_trig_i[LANE_ROLL].c) * PW'(in_trig_i[LANE_PITCH].c);
      pp0_q[PR_SS] <= PW'(in_trig_i[LANE_ROLL].s) * PW'(in_trig_i[LANE_PITCH].s);
      pp0_q[PR_SC] <= PW'(in_trig_i[LANE_ROLL].s) * PW'(in_trig_i[LANE_PITCH].c);
      pp0_q[PR_CS] <= PW'(in_trig_i[LANE_ROLL].c) * PW'(in_trig_i[LANE_PITCH].s);
      cy0_q        <= in_trig_i[LANE_YAW].c;
      sy0_q        <= in_trig_i[LANE_YAW].s;
    end
    if (rdy[1]) begin
      for (int k = 0; k < 4; k++) begin
        pr1_q[k] <= round_q(pp0_q[k]);
      end
      cy1_q <= cy0_q;
      sy1_q <= sy0_q;
    end
    if (rdy[2]) begin
      for (int k = 0; k < 4; k++) begin
        tp2_q[2*k]   <= PW'(pr1_q[k]) * PW'(cy1_q);
        tp2_q[2*k+1] <= PW'(pr1_q[k]) * PW'(sy1_q);
      end
    end
    if (rdy[3]) begin
      for (int k = 0; k < 8; k++) begin
        tr3_q[k] <= round_q(tp2_q[k]);
      end
    end
    if (rdy[4]) begin
      quat_q <= quat_d;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign out_quat_o  = quat_q;

endmodule

/* design/euler_to_quaternion.sv */
// Top level of the ZYX Euler angle to quaternion converter: angle folding, CORDIC chain, products.
//
//  Channel   Direction  Signals                          Content
//  s_axis    input      s_axis_tvalid_i/tready_o/tdata_i roll, pitch, yaw (deg, 7 frac bits)
//  m_axis    output     m_axis_tvalid_o/tready_i/tdata_o quat w, x, y, z (signed, Q1.OUT_FRAC_BITS)
//
// The block takes one transfer per clock cycle while s_axis_tready_o is high and holds no
// state between samples. The pipeline has 18 CORDIC cells (the half-angle fold sits in front
// of the first) and five stages of pair products, rounding, triple products, rounding and output.
// Each stage carries its own valid bit, so bubbles collapse and the block keeps taking
// input while the output register holds a result that waits; it stalls only when every
// stage is full. Reset clears the valid bits; data registers are not reset.
module euler_to_quaternion #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: roll_deg[15:0], pitch_deg[31:16], yaw_deg[47:32].
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48].
  output logic [63:0] m_axis_tdata_o
);
  import e2q_pkg::*;

  lane_t [NUM_LANES-1:0]   chain_lanes [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]   chain_valid;
  logic [CORDIC_STEPS:0]   chain_ready;
  trig_t [NUM_LANES-1:0]   trig;
  quat_t                   quat;

  // Half angle is the raw angle times 256 (degrees with 16 fraction bits). Half angles
  // beyond a quarter turn are folded by half a turn, which negates cosine and sine.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic signed [ANGLE_W+7:0] half;
      logic signed [ZW-1:0]      z;
      half = {s_axis_tdata_i[ANGLE_W*l +: ANGLE_W], 8'h00};
      z    = ZW'(half);
      chain_lanes[0][l].x = CORDIC_GAIN;
      chain_lanes[0][l].y = '0;
      if (z > DEG_90) begin
        chain_lanes[0][l].z    = z - DEG_180;
        chain_lanes[0][l].flip = 1'b1;
      end else if (z < -DEG_90) begin
        chain_lanes[0][l].z    = z + DEG_180;
        chain_lanes[0][l].flip = 1'b1;
      end else begin
        chain_lanes[0][l].z    = z;
        chain_lanes[0][l].flip = 1'b0;
      end
    end
  end

  assign chain_valid[0]  = s_axis_tvalid_i;
  assign s_axis_tready_o = chain_ready[0];

  // Each cell performs one CORDIC iteration for all three angles and passes its
  // result to the next cell on every cycle that the next cell can take it.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    e2q_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_lanes_i  (chain_lanes[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_lanes_o (chain_lanes[k+1])
    );
  end

  // Undo the fold and narrow to the product width; magnitudes stay near one.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic signed [XW-1:0] xn;
      logic signed [XW-1:0] yn;
      xn = chain_lanes[CORDIC_STEPS][l].flip ? -chain_lanes[CORDIC_STEPS][l].x
                                             :  chain_lanes[CORDIC_STEPS][l].x;
      yn = chain_lanes[CORDIC_STEPS][l].flip ? -chain_lanes[CORDIC_STEPS][l].y
                                             :  chain_lanes[CORDIC_STEPS][l].y;
      trig[l].c = xn[CW-1:0];
      trig[l].s = yn[CW-1:0];
    end
  end

  e2q_quat_tail #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[CORDIC_STEPS]),
    .in_ready_o  (chain_ready[CORDIC_STEPS]),
    .in_trig_i   (trig),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_quat_o  (quat)
  );

  assign m_axis_tdata_o = quat;

endmodule
